/* sv/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dpcd_pkg.sv */
package dpcd_pkg;
  localparam int RATE_BATCH_DEF = 100;
  localparam int COINC_BATCH_DEF = 10;
  localparam int MAX_PULSE_SAMPLES_DEF = 65535;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int SAMPLE_W = 12;
  localparam int TIME_W = 32;
  localparam int SUM_W = 28;
  localparam int CNT_W = 16;
  localparam int WIN_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  localparam logic [1:0] KIND_A = 2'd0;
  localparam logic [1:0] KIND_B = 2'd1;
  localparam logic [1:0] KIND_COINC = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [TIME_W-1:0] time_val;
    logic [SAMPLE_W-1:0] amp;
    logic [TIME_W-1:0] number;
    logic done;
    logic [TIME_W-1:0] span;
    logic last;
  } event_t;

  typedef struct packed {
    logic start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;
endpackage

/* sv/dpcd_divider.sv */
module dpcd_divider (
  input  logic clk,
  input  logic rst,
  input  dpcd_pkg::div_req_t req,
  output dpcd_pkg::div_rsp_t rsp
);
  import dpcd_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo;
  logic [CNT_W:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [STEP_W-1:0] steps;
  logic busy;
  logic done;
  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem[CNT_W-1:0], quo[SUM_W-1]};
    diff = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= diff;
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

/* sv/dual_pulse_coincidence_detector.sv */
// dual_pulse_coincidence_detector
// input stream s_axis: tdata carries sample_a, sample_b and time_us; one
// transfer is one sample pair. output stream m_axis: up to three event
// transfers per sample pair (pulse A, pulse B, coincidence), the last one
// flagged in tuser. config port: cfg_we, cfg_index, cfg_data, write only;
// the user must write it while the block is idle; the block has no check.
// each pulse that ends goes through the shared 28-step restoring divider
// (mean amplitude) and the emit step, and first waits for the previous
// transfer to leave the output register; a coincidence adds one output
// transfer.
// s_axis_tready is high only while the sequencer is idle.
// when the receiver stalls the event waits in the output register and the
// sequencer waits with it; nothing is dropped.
// reset clears thresholds to 500/200, window to 100 and all pulse, pending,
// counter and batch state.
module dual_pulse_coincidence_detector #(
  parameter int RATE_BATCH = dpcd_pkg::RATE_BATCH_DEF,
  parameter int COINC_BATCH = dpcd_pkg::COINC_BATCH_DEF,
  parameter int MAX_PULSE_SAMPLES = dpcd_pkg::MAX_PULSE_SAMPLES_DEF,
  parameter int SAMPLE_BITS = dpcd_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_a[11:0], sample_b[23:12], time_us[55:24]
  input  logic [55:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // event_kind[1:0], event_time[33:2], amplitude[45:34], event_number[77:46],
  // batch_done[78], batch_span[110:79], zero fill
  output logic [111:0] m_axis_tdata,
  // last_result
  output logic m_axis_tuser,
  input  logic cfg_we,
  input  logic [dpcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dpcd_pkg::*;

  localparam int BI_W = $clog2(RATE_BATCH + 1);
  localparam int CB_W = $clog2(COINC_BATCH + 1);
  localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHAN, ST_DIV, ST_EMIT, ST_COINC, ST_CEMIT
  } state_t;

  state_t state;
  logic ch;
  logic [SAMPLE_W-1:0] high_thr, low_thr;
  logic [WIN_W-1:0] window;
  logic [SAMPLE_W-1:0] samp [2];
  logic [TIME_W-1:0] now;
  logic armed [2];
  logic [SUM_W-1:0] psum [2];
  logic [CNT_W-1:0] pcnt [2];
  logic [TIME_W-1:0] last_high [2];
  logic [TIME_W-1:0] pend_time [2];
  logic pend_valid [2];
  logic [TIME_W-1:0] ch_events [2];
  logic [BI_W-1:0] bidx [2];
  logic [TIME_W-1:0] bfirst [2];
  logic [TIME_W-1:0] c_events;
  logic [CB_W-1:0] cidx;
  logic [TIME_W-1:0] cfirst;
  event_t ev;
  logic ovalid;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [TIME_W-1:0] d, mag;
  logic [SAMPLE_W-1:0] cur;
  logic [BI_W-1:0] bnext;
  logic [CB_W-1:0] cnext;
  logic b_ends;
  logic coinc_hit;

  dpcd_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cur = samp[ch];
  assign bnext = bidx[ch] + 1'b1;
  assign cnext = cidx + 1'b1;
  assign d = pend_time[0] - pend_time[1];
  assign mag = d[TIME_W-1] ? (TIME_W'(0) - d) : d;
  assign b_ends = !(samp[1] >= high_thr) && (samp[1] < low_thr) && armed[1];
  assign coinc_hit = pend_valid[0] && pend_valid[1] && !(d[TIME_W-1] && mag[TIME_W-1])
                     && (mag < TIME_W'(window));

  always_comb begin
    dreq.start = (state == ST_CHAN) && !ovalid && !(cur >= high_thr) && (cur < low_thr)
                 && armed[ch] && (pcnt[ch] != '0);
    dreq.dividend = psum[ch];
    dreq.divisor = pcnt[ch];
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata = {1'b0, ev.span, ev.done, ev.number, ev.amp, ev.time_val, ev.kind};
  assign m_axis_tuser = ev.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovalid <= 1'b0;
      high_thr <= 12'd500;
      low_thr <= 12'd200;
      window <= 16'd100;
      for (int i = 0; i < 2; i++) begin
        armed[i] <= 1'b0; psum[i] <= '0; pcnt[i] <= '0; last_high[i] <= '0;
        pend_time[i] <= '0; pend_valid[i] <= 1'b0; ch_events[i] <= '0;
        bidx[i] <= '0; bfirst[i] <= '0;
      end
      c_events <= '0; cidx <= '0; cfirst <= '0;
      ch <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HIGH: high_thr <= cfg_data[SAMPLE_W-1:0];
          REG_LOW: low_thr <= cfg_data[SAMPLE_W-1:0];
          REG_WINDOW: window <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid && m_axis_tready) ovalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          samp[0] <= s_axis_tdata[11:0] & SMASK;
          samp[1] <= s_axis_tdata[23:12] & SMASK;
          now <= s_axis_tdata[55:24];
          ch <= 1'b0;
          state <= ST_CHAN;
        end
        ST_CHAN: begin
          if (cur >= high_thr) begin
            armed[ch] <= 1'b1;
            if (pcnt[ch] < CNT_W'(MAX_PULSE_SAMPLES)) begin
              psum[ch] <= psum[ch] + SUM_W'(cur);
              pcnt[ch] <= pcnt[ch] + 1'b1;
            end
            last_high[ch] <= now;
            if (ch) state <= ST_COINC; else ch <= 1'b1;
          end else if (cur < low_thr && armed[ch]) begin
            // wait until the previous event has left the output register
            if (!ovalid) begin
              ev.kind <= ch ? KIND_B : KIND_A;
              ev.time_val <= last_high[ch];
              ev.number <= ch_events[ch] + 1'b1;
              ch_events[ch] <= ch_events[ch] + 1'b1;
              pend_time[ch] <= last_high[ch];
              pend_valid[ch] <= 1'b1;
              if (bidx[ch] == '0) bfirst[ch] <= last_high[ch];
              if (bnext >= BI_W'(RATE_BATCH)) begin
                ev.done <= 1'b1;
                ev.span <= last_high[ch] - ((bidx[ch] == '0) ? last_high[ch] : bfirst[ch]);
                bidx[ch] <= '0;
              end else begin
                ev.done <= 1'b0;
                ev.span <= '0;
                bidx[ch] <= bnext;
              end
              ev.amp <= '0;
              state <= (pcnt[ch] != '0) ? ST_DIV : ST_EMIT;
            end
          end else begin
            if (ch) state <= ST_COINC; else ch <= 1'b1;
          end
        end
        ST_DIV: if (drsp.done) begin
          ev.amp <= drsp.quotient[SAMPLE_W-1:0] & SMASK;
          state <= ST_EMIT;
        end
        ST_EMIT: if (!ovalid) begin
          armed[ch] <= 1'b0; psum[ch] <= '0; pcnt[ch] <= '0;
          // last unless a pulse on b or a coincidence follows
          ev.last <= (!ch && b_ends) ? 1'b0 : !coinc_hit;
          ovalid <= 1'b1;
          if (ch) state <= ST_COINC; else begin ch <= 1'b1; state <= ST_CHAN; end
        end
        ST_COINC: if (!ovalid) begin
          if (coinc_hit) begin
            ev.kind <= KIND_COINC;
            ev.time_val <= pend_time[0];
            ev.amp <= '0;
            ev.number <= c_events + 1'b1;
            c_events <= c_events + 1'b1;
            if (cidx == '0) cfirst <= pend_time[0];
            if (cnext >= CB_W'(COINC_BATCH)) begin
              ev.done <= 1'b1;
              ev.span <= pend_time[0] - ((cidx == '0) ? pend_time[0] : cfirst);
              cidx <= '0;
            end else begin
              ev.done <= 1'b0; ev.span <= '0; cidx <= cnext;
            end
            ev.last <= 1'b1;
            pend_valid[0] <= 1'b0; pend_valid[1] <= 1'b0;
            state <= ST_CEMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CEMIT: begin
          ovalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `CHK_IMPL(a_ready_idle, s_axis_tready, !ovalid || state == ST_IDLE, "ready while busy")
  `CHK_NEXT(a_div_start, dreq.start, drsp.busy, "divider did not start")
  `CHK_IMPL(a_div_state, drsp.busy, state == ST_DIV, "divider busy outside divide")
endmodule

/* tb/tb_dual_pulse_coincidence_detector.sv */
module tb_dual_pulse_coincidence_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import dpcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 3000000;

  class pulse_scoreboard;
    logic [11:0] high_th;
    logic [11:0] low_th;
    logic [15:0] window;
    bit armed[2];
    logic [27:0] sum[2];
    logic [15:0] cnt[2];
    logic [31:0] last_hi[2];
    logic [31:0] pend_t[2];
    bit pend_v[2];
    logic [31:0] ev_num[2];
    logic [6:0] bidx[2];
    logic [31:0] bfirst[2];
    logic [31:0] co_num;
    logic [3:0] co_idx;
    logic [31:0] co_first;
    event_t due[$];
    event_t fresh[$];
    int errors;

    function new();
      high_th = 500;
      low_th = 200;
      window = 100;
      for (int c = 0; c < 2; c++) begin
        armed[c] = 0; sum[c] = 0; cnt[c] = 0; last_hi[c] = 0; pend_t[c] = 0;
        pend_v[c] = 0; ev_num[c] = 0; bidx[c] = 0; bfirst[c] = 0;
      end
      co_num = 0;
      co_idx = 0;
      co_first = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HIGH: high_th = data[11:0];
        REG_LOW: low_th = data[11:0];
        REG_WINDOW: window = data;
        default: ;
      endcase
    endfunction

    function void run_channel(int c, logic [11:0] s, logic [31:0] now);
      event_t e;
      if (s >= high_th) begin
        armed[c] = 1;
        if (cnt[c] < MAX_PULSE_SAMPLES_DEF) begin
          sum[c] = sum[c] + s;
          cnt[c] = cnt[c] + 1;
        end
        last_hi[c] = now;
      end else if (s < low_th && armed[c]) begin
        e = '0;
        e.kind = (c == 0) ? KIND_A : KIND_B;
        e.time_val = last_hi[c];
        if (cnt[c] != 0) e.amp = 12'(sum[c] / cnt[c]);
        if (bidx[c] == 0) bfirst[c] = last_hi[c];
        bidx[c] = bidx[c] + 1;
        if (bidx[c] >= RATE_BATCH_DEF) begin
          e.done = 1;
          e.span = last_hi[c] - bfirst[c];
          bidx[c] = 0;
        end
        ev_num[c] = ev_num[c] + 1;
        e.number = ev_num[c];
        pend_t[c] = last_hi[c];
        pend_v[c] = 1;
        armed[c] = 0;
        sum[c] = 0;
        cnt[c] = 0;
        fresh.push_back(e);
      end
    endfunction

    function void note_sample(logic [11:0] sa, logic [11:0] sb, logic [31:0] now);
      logic [31:0] d;
      logic [31:0] mag;
      event_t e;
      fresh.delete();
      run_channel(0, sa, now);
      run_channel(1, sb, now);
      if (pend_v[0] && pend_v[1]) begin
        d = pend_t[0] - pend_t[1];
        mag = d[31] ? -d : d;
        if (mag < window) begin
          e = '0;
          e.kind = KIND_COINC;
          e.time_val = pend_t[0];
          co_num = co_num + 1;
          e.number = co_num;
          if (co_idx == 0) co_first = pend_t[0];
          co_idx = co_idx + 1;
          if (co_idx >= COINC_BATCH_DEF) begin
            e.done = 1;
            e.span = pend_t[0] - co_first;
            co_idx = 0;
          end
          pend_v[0] = 0;
          pend_v[1] = 0;
          fresh.push_back(e);
        end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1;
      foreach (fresh[i]) due.push_back(fresh[i]);
    endfunction

    function void check_event(logic [111:0] data, logic user);
      event_t got;
      event_t want;
      got.kind = data[1:0];
      got.time_val = data[33:2];
      got.amp = data[45:34];
      got.number = data[77:46];
      got.done = data[78];
      got.span = data[110:79];
      got.last = user;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected event transfer: %p", got);
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("event mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pulse_scoreboard board = new();
  int send_idle = 9;
  int recv_idle = 51;
  longint cycles = 0;
  logic [31:0] now_us = 0;

  dual_pulse_coincidence_detector u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_dual_pulse_coincidence_detector: errors");
      $finish;
    end
  end

  // event receiver with random back-pressure
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_event(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_sample(logic [11:0] sa, logic [11:0] sb, logic [31:0] t);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {t, sb, sa};
    do @(posedge clk); while (!s_axis_tready);
    board.note_sample(sa, sb, t);
  endtask

  task automatic settle();
    s_axis_tvalid <= 0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while idle: valid dropped and all events drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    s_axis_tvalid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_levels(logic [11:0] hi, logic [11:0] lo, logic [15:0] win);
    settle();
    write_reg(REG_HIGH, 16'(hi));
    write_reg(REG_LOW, 16'(lo));
    write_reg(REG_WINDOW, win);
  endtask

  function automatic logic [11:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 12'($urandom_range(4095, board.high_th));
    if (r < 90) return (board.low_th == 0) ? 12'd0 : 12'($urandom_range(board.low_th - 1, 0));
    return 12'($urandom);
  endfunction

  task automatic random_samples(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) now_us = now_us + $urandom_range(60, 1);
      else now_us = $urandom;
      send_sample(pick_sample(), pick_sample(), now_us);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // both channels, coincidence at equal times
    send_sample(12'd4095, 12'd4095, 32'd1000);
    send_sample(12'd0, 12'd0, 32'd1010);
    // exact thresholds
    send_sample(12'd500, 12'd0, 32'd2000);
    send_sample(12'd199, 12'd0, 32'd2001);
    send_sample(12'd600, 12'd700, 32'd3000);
    send_sample(12'd200, 12'd199, 32'd3001);
    send_sample(12'd0, 12'd0, 32'd3050);
    // overwritten pending time on A
    send_sample(12'd4095, 12'd0, 32'd5000);
    send_sample(12'd0, 12'd0, 32'd5001);
    send_sample(12'd4095, 12'd0, 32'd9000);
    send_sample(12'd0, 12'd0, 32'd9001);
    send_sample(12'd0, 12'd4095, 32'd9050);
    send_sample(12'd0, 12'd0, 32'd9060);
    // coincidence across timestamp wrap
    send_sample(12'd4095, 12'd0, 32'hFFFF_FFF0);
    send_sample(12'd0, 12'd4095, 32'h0000_0010);
    send_sample(12'd0, 12'd0, 32'h0000_0020);

    // low above high, full window, unused index ignored
    set_levels(12'd300, 12'd1000, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(12'd500, 12'd2048, 32'd100);
    send_sample(12'd999, 12'd4095, 32'd200);
    send_sample(12'd0, 12'd0, 32'd300);
    // half-range difference never matches
    send_sample(12'd4095, 12'd0, 32'h8000_0005);
    send_sample(12'd0, 12'd4095, 32'd5);
    send_sample(12'd0, 12'd0, 32'd6);

    // top thresholds, zero window
    set_levels(12'd4095, 12'd4095, 16'd0);
    send_sample(12'd4095, 12'd4094, 32'd7000);
    send_sample(12'd4094, 12'd4095, 32'd7001);
    send_sample(12'd0, 12'd0, 32'd7002);
    // zero thresholds: everything accumulates
    set_levels(12'd0, 12'd0, 16'd1);
    send_sample(12'd0, 12'd0, 32'd7100);
    send_sample(12'd4095, 12'd0, 32'd7101);
    set_levels(12'd1, 12'd1, 16'd100);
    send_sample(12'd0, 12'd0, 32'd7102);

    set_levels(12'd500, 12'd200, 16'd100);
    send_idle = 9;
    recv_idle = 51;
    now_us = 32'd10000;
    random_samples(20);
    // hold off until every event is out
    settle();
    random_samples(20);

    set_levels(12'($urandom_range(3000, 1500)), 12'($urandom_range(1400, 1)),
               16'($urandom_range(3000, 1)));
    send_idle = 51;
    recv_idle = 9;
    random_samples(15);

    set_levels(12'($urandom_range(4095, 100)), 12'($urandom_range(99, 1)),
               16'($urandom_range(200, 20)));
    send_idle = 0;
    recv_idle = 0;
    random_samples(15);

    @(posedge clk);
    s_axis_tvalid <= 0;
    settle();
    if (board.due.size() != 0) board.errors++;
    if (board.errors == 0) begin
      $display("tb_dual_pulse_coincidence_detector: clean");
    end else begin
      $display("tb_dual_pulse_coincidence_detector: errors");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+sv
sv/dpcd_pkg.sv
sv/dpcd_divider.sv
sv/dual_pulse_coincidence_detector.sv
tb/tb_dual_pulse_coincidence_detector.sv
